// ----- hdl/ssr_pkg.sv -----
// ============================================================================
// ssr_pkg : shared types and constants for the servo slew ramp
// Field widths, command codes, register indexes and the fixed-point
// constants of the angle-to-pulse scaler.
// ============================================================================
package ssr_pkg;

   localparam int CHANNELS_DEF = 16;

   localparam int CH_W       = 4;
   localparam int ANG_W      = 15;
   localparam int PULSE_W    = 12;
   localparam int STEP_W     = 15;
   localparam int DB_W       = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   // full scale angle in centidegrees
   localparam logic [ANG_W-1:0] FULL_SCALE = 15'd18000;

   // scaler: |span| * angle, then divide by full scale via reciprocal
   localparam int PROD_W      = PULSE_W + ANG_W;
   localparam int RECIP_SHIFT = 27;
   localparam int RECIP_W     = 13;
   localparam int RPROD_W     = PROD_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd18000);

   localparam int QUEUE_DEPTH = 2;

   // request codes
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_PLACE  = 2'd1;
   localparam logic [1:0] OP_TARGET = 2'd2;
   localparam logic [1:0] OP_ENABLE = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_MIN  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_MAX  = 2'd3;

   localparam logic [STEP_W-1:0]  STEP_LIMIT_RST = 15'd164;
   localparam logic [DB_W-1:0]    DEADBAND_RST   = 10'd10;
   localparam logic [PULSE_W-1:0] PULSE_MIN_RST  = 12'd150;
   localparam logic [PULSE_W-1:0] PULSE_MAX_RST  = 12'd600;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [CH_W-1:0]  channel;
      logic [ANG_W-1:0] angle;
      logic             enable;
   } ssr_req_type;

   typedef struct packed {
      logic [CH_W-1:0]    out_channel;
      logic [PULSE_W-1:0] pulse;
      logic               last;
   } ssr_rsp_type;

   // classified command between front and back
   typedef struct packed {
      logic [1:0]       op;
      logic [CH_W-1:0]  chan;
      logic [ANG_W-1:0] angle;
      logic             enable;
   } ssr_cmd_type;

   // angle item handed to the scaler
   typedef struct packed {
      logic [CH_W-1:0]  chan;
      logic [ANG_W-1:0] angle;
      logic             last;
   } ssr_ang_type;

   typedef struct packed {
      logic [STEP_W-1:0]  step_limit;
      logic [DB_W-1:0]    deadband;
      logic [PULSE_W-1:0] pulse_min;
      logic [PULSE_W-1:0] pulse_max;
   } ssr_cfg_type;

endpackage

// ----- hdl/ssr_front.sv -----
// ============================================================================
// ssr_front : request intake
// Saturate the angle, drop requests aimed at channels that do not exist,
// and hand the rest to the command queue.
// ============================================================================
module ssr_front import ssr_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic        req_valid,
   output logic        req_ready,
   input  ssr_req_type req_data,
   output logic        cmd_valid,
   input  logic        cmd_ready,
   output ssr_cmd_type cmd
);

   logic keep;

   // ticks always pass; other requests need an existing channel
   assign keep = (req_data.req_type == OP_TICK) || (int'(req_data.channel) < CHANNELS);

   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid && keep;

   always_comb begin
      cmd.op     = req_data.req_type;
      cmd.chan   = req_data.channel;
      cmd.enable = req_data.enable;
      cmd.angle  = (req_data.angle > FULL_SCALE) ? FULL_SCALE : req_data.angle;
   end

endmodule

// ----- hdl/ssr_cmd_queue.sv -----
// ============================================================================
// ssr_cmd_queue : short command queue
// Decouple request intake from the channel sweep.
// ============================================================================
module ssr_cmd_queue import ssr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_ready,
   input  ssr_cmd_type push_data,
   output logic        pop_valid,
   input  logic        pop_ready,
   output ssr_cmd_type pop_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   ssr_cmd_type      entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/ssr_back.sv -----
// ============================================================================
// ssr_back : channel state and tick sweep
// Execute commands, keep per-channel flags and angle memories, and walk
// all channels on a tick, one per cycle while ang_ready is high, emitting moved angles.
// ============================================================================
module ssr_back import ssr_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  ssr_cfg_type cfg,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  ssr_cmd_type cmd,
   output logic        ang_valid,
   input  logic        ang_ready,
   output ssr_ang_type ang
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

   logic [CHANNELS-1:0] present_ff, present_in;
   logic [CHANNELS-1:0] enabled_ff, enabled_in;
   logic [ANG_W-1:0]    cur_mem [CHANNELS];
   logic [ANG_W-1:0]    tgt_mem [CHANNELS];

   logic             sweep_ff, sweep_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             a_live_ff, a_live_in;
   logic             a_active_ff, a_active_in;
   logic             a_end_ff, a_end_in;
   logic [IDX_W-1:0] a_idx_ff, a_idx_in;
   logic [ANG_W-1:0] cur_rd_ff, tgt_rd_ff;
   logic             flush_ff, flush_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic [ANG_W-1:0] pend_ang_ff, pend_ang_in;

   logic              adv, busy, take;
   logic [IDX_W-1:0]  cmd_idx;
   logic [STEP_W-1:0] lim;
   logic [ANG_W:0]    diff;
   logic [ANG_W-1:0]  mag;
   logic [ANG_W-1:0]  new_cur;
   logic              move;
   logic              cur_we, tgt_we;
   logic [IDX_W-1:0]  cur_wa;
   logic [ANG_W-1:0]  cur_wd;

   assign adv       = ang_ready;
   assign busy      = sweep_ff || a_live_ff || flush_ff;
   assign cmd_ready = !busy && adv;
   assign take      = cmd_valid && cmd_ready;
   assign cmd_idx   = IDX_W'(cmd.chan);

   // slew step on the channel held in the registered read
   always_comb begin
      lim  = (cfg.step_limit == '0) ? STEP_W'(1) : cfg.step_limit;
      diff = {1'b0, tgt_rd_ff} - {1'b0, cur_rd_ff};
      mag  = diff[ANG_W] ? ANG_W'(-diff) : ANG_W'(diff);
      move = a_live_ff && a_active_ff && (mag > ANG_W'(cfg.deadband));
      if (mag > lim) begin
         new_cur = diff[ANG_W] ? cur_rd_ff - lim : cur_rd_ff + lim;
      end else begin
         new_cur = tgt_rd_ff;
      end
   end

   // hold one moved channel back so the last of the run can be flagged
   always_comb begin
      ang_valid = 1'b0;
      ang       = '0;
      priority if (take && cmd.op == OP_PLACE) begin
         ang_valid = 1'b1;
         ang.chan  = cmd.chan;
         ang.angle = cmd.angle;
         ang.last  = 1'b1;
      end else if (flush_ff && pend_valid_ff) begin
         ang_valid = 1'b1;
         ang.chan  = CH_W'(pend_idx_ff);
         ang.angle = pend_ang_ff;
         ang.last  = 1'b1;
      end else if (move && pend_valid_ff) begin
         ang_valid = 1'b1;
         ang.chan  = CH_W'(pend_idx_ff);
         ang.angle = pend_ang_ff;
         ang.last  = 1'b0;
      end else begin
         ang_valid = 1'b0;
      end
   end

   always_comb begin
      present_in    = present_ff;
      enabled_in    = enabled_ff;
      sweep_in      = sweep_ff;
      idx_in        = idx_ff;
      a_live_in     = a_live_ff;
      a_active_in   = a_active_ff;
      a_end_in      = a_end_ff;
      a_idx_in      = a_idx_ff;
      flush_in      = flush_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      pend_ang_in   = pend_ang_ff;
      if (adv) begin
         a_live_in   = sweep_ff;
         a_active_in = present_ff[idx_ff] && enabled_ff[idx_ff];
         a_idx_in    = idx_ff;
         a_end_in    = (idx_ff == LAST_IDX);
         flush_in    = a_live_ff && a_end_ff;
         if (sweep_ff) begin
            idx_in = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               sweep_in = 1'b0;
            end
         end
         if (move) begin
            pend_valid_in = 1'b1;
            pend_idx_in   = a_idx_ff;
            pend_ang_in   = new_cur;
         end
         if (flush_ff) begin
            pend_valid_in = 1'b0;
         end
         if (take) begin
            unique case (cmd.op)
               OP_TICK: begin
                  sweep_in = 1'b1;
                  idx_in   = '0;
               end
               OP_PLACE: begin
                  present_in[cmd_idx] = 1'b1;
                  enabled_in[cmd_idx] = 1'b1;
               end
               OP_TARGET: begin
                  present_in = present_ff;
               end
               OP_ENABLE: begin
                  enabled_in[cmd_idx] = cmd.enable;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff    <= '0;
         enabled_ff    <= '0;
         sweep_ff      <= 1'b0;
         idx_ff        <= '0;
         a_live_ff     <= 1'b0;
         a_end_ff      <= 1'b0;
         flush_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         present_ff    <= present_in;
         enabled_ff    <= enabled_in;
         sweep_ff      <= sweep_in;
         idx_ff        <= idx_in;
         a_live_ff     <= a_live_in;
         a_end_ff      <= a_end_in;
         flush_ff      <= flush_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_active_ff <= a_active_in;
      a_idx_ff    <= a_idx_in;
      pend_idx_ff <= pend_idx_in;
      pend_ang_ff <= pend_ang_in;
   end

   // angle memories: one write port each, registered read at the sweep index
   assign cur_we = adv && (move || (take && cmd.op == OP_PLACE));
   assign cur_wa = move ? a_idx_ff : cmd_idx;
   assign cur_wd = move ? new_cur : cmd.angle;
   assign tgt_we = take && (cmd.op == OP_PLACE || cmd.op == OP_TARGET);

   always_ff @(posedge clock) begin
      if (adv) begin
         cur_rd_ff <= cur_mem[idx_ff];
      end
      if (cur_we) begin
         cur_mem[cur_wa] <= cur_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tgt_rd_ff <= tgt_mem[idx_ff];
      end
      if (tgt_we) begin
         tgt_mem[cmd_idx] <= cmd.angle;
      end
   end

endmodule

// ----- hdl/ssr_scaler.sv -----
// ============================================================================
// ssr_scaler : angle to PWM off count
// pulse_min + trunc((pulse_max - pulse_min) * angle / 18000) in three
// stages: magnitude product, reciprocal product, correct and offset.
// ============================================================================
module ssr_scaler import ssr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  ssr_cfg_type cfg,
   input  logic        ang_valid,
   output logic        ang_ready,
   input  ssr_ang_type ang,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ssr_rsp_type rsp_data
);

   logic              adv;
   logic [PULSE_W:0]  span;
   logic [PULSE_W-1:0] span_mag;

   logic              s1_valid_ff;
   logic [PROD_W-1:0] s1_m_ff;
   logic              s1_neg_ff;
   logic [CH_W-1:0]   s1_chan_ff;
   logic              s1_last_ff;

   logic [RPROD_W-1:0] rprod;
   logic               s2_valid_ff;
   logic [PROD_W-1:0]  s2_m_ff;
   logic [PULSE_W-1:0] s2_q_ff;
   logic               s2_neg_ff;
   logic [CH_W-1:0]    s2_chan_ff;
   logic               s2_last_ff;

   logic [PROD_W-1:0]  qm, rem;
   logic [PULSE_W-1:0] q, delta;

   logic        out_valid_ff;
   ssr_rsp_type out_ff, out_in;

   assign adv       = !out_valid_ff || rsp_ready;
   assign ang_ready = adv;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   assign span     = {1'b0, cfg.pulse_max} - {1'b0, cfg.pulse_min};
   assign span_mag = span[PULSE_W] ? PULSE_W'(-span) : PULSE_W'(span);

   // quotient estimate is exact or one short
   assign rprod = RPROD_W'(s1_m_ff) * RPROD_W'(RECIP);

   always_comb begin
      qm     = PROD_W'(s2_q_ff) * PROD_W'(FULL_SCALE);
      rem    = s2_m_ff - qm;
      q      = s2_q_ff + PULSE_W'(rem >= PROD_W'(FULL_SCALE));
      delta  = s2_neg_ff ? PULSE_W'(-q) : q;
      out_in.out_channel = s2_chan_ff;
      out_in.pulse       = cfg.pulse_min + delta;
      out_in.last        = s2_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= ang_valid;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_m_ff    <= PROD_W'(span_mag) * PROD_W'(ang.angle);
         s1_neg_ff  <= span[PULSE_W];
         s1_chan_ff <= ang.chan;
         s1_last_ff <= ang.last;
         s2_m_ff    <= s1_m_ff;
         s2_q_ff    <= rprod[RECIP_SHIFT +: PULSE_W];
         s2_neg_ff  <= s1_neg_ff;
         s2_chan_ff <= s1_chan_ff;
         s2_last_ff <= s1_last_ff;
         out_ff     <= out_in;
      end
   end

endmodule

// ----- hdl/servo_slew_ramp_core.sv -----
// ============================================================================
// servo_slew_ramp_core : multi-channel servo ramp generator
// Slew-rate limited angle ramps per channel, emitted as PWM off counts.
// ============================================================================
//
//  channel  | ports                          | moves
//  ---------+--------------------------------+-------------------------------
//  request  | req_valid/req_ready/req_data   | tick, place, set target/enable
//  response | rsp_valid/rsp_ready/rsp_data   | channel, pulse, last flag
//  csr      | csr_we/csr_index/csr_wdata     | step limit, deadband, pulses
//
//  A tick holds the sweep engine through accept, one channel read per cycle
//  unless stalled, the last slew step and a flush that flags the last result.
//  The scaler has three register stages, the last one driving rsp_data.
//  Reset is synchronous; it clears the flags and loads the register defaults.
//  A stalled response stalls sweep and scaler; the queue fills meanwhile.
//
module servo_slew_ramp_core import ssr_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ssr_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ssr_rsp_type           rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   ssr_cfg_type cfg_ff, cfg_in;

   logic        fr_valid, fr_ready;
   ssr_cmd_type fr_cmd;
   logic        q_valid, q_ready;
   ssr_cmd_type q_cmd;
   logic        ang_valid, ang_ready;
   ssr_ang_type ang;

   // configuration registers: write only, no wait
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_STEP_LIMIT: cfg_in.step_limit = STEP_W'(csr_wdata);
            CSR_DEADBAND:   cfg_in.deadband   = DB_W'(csr_wdata);
            CSR_PULSE_MIN:  cfg_in.pulse_min  = PULSE_W'(csr_wdata);
            CSR_PULSE_MAX:  cfg_in.pulse_max  = PULSE_W'(csr_wdata);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_limit <= STEP_LIMIT_RST;
         cfg_ff.deadband   <= DEADBAND_RST;
         cfg_ff.pulse_min  <= PULSE_MIN_RST;
         cfg_ff.pulse_max  <= PULSE_MAX_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // classify and drop requests for absent channels
   ssr_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (fr_valid),
      .cmd_ready (fr_ready),
      .cmd       (fr_cmd)
   );

   // hold commands while a sweep is running
   ssr_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_data  (fr_cmd),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_cmd)
   );

   // channel state, tick sweep and slew step
   ssr_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (q_valid),
      .cmd_ready (q_ready),
      .cmd       (q_cmd),
      .ang_valid (ang_valid),
      .ang_ready (ang_ready),
      .ang       (ang)
   );

   // convert angles to PWM off counts and drive the response transaction
   ssr_scaler u_scaler (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .ang_valid (ang_valid),
      .ang_ready (ang_ready),
      .ang       (ang),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- test/servo_ramp_checker.sv -----
`timescale 1ns / 100ps
// ============================================================================
// servo_ramp_checker : result predictor and scoreboard for the servo ramp
// Shadows the register file and the per-channel ramp state, works out the
// pulse results of every accepted request and matches them in order
// against the accepted responses.
// ============================================================================
module servo_ramp_checker import ssr_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  ssr_req_type           req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  ssr_rsp_type           rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending
);

   ssr_cfg_type      cfg;
   logic             present   [CHANNELS];
   logic             enabled   [CHANNELS];
   logic [ANG_W-1:0] cur_angle [CHANNELS];
   logic [ANG_W-1:0] tgt_angle [CHANNELS];
   ssr_rsp_type      pulse_q   [$];
   int               failures = 0;

   // exact span * angle / full scale, truncated toward zero
   function automatic logic [PULSE_W-1:0] angle_to_count(input logic [ANG_W-1:0] ang);
      longint span;
      span = longint'(cfg.pulse_max) - longint'(cfg.pulse_min);
      return PULSE_W'(longint'(cfg.pulse_min) + span * longint'(ang) / longint'(FULL_SCALE));
   endfunction

   task automatic ramp_request(input ssr_req_type r);
      logic [ANG_W-1:0] ang;
      int               lim;
      int               diff;
      int               nxt;
      bit               moved;
      ssr_rsp_type      item;
      ang   = (r.angle > FULL_SCALE) ? FULL_SCALE : r.angle;
      moved = 1'b0;
      case (r.req_type)
         OP_TICK: begin
            lim = (cfg.step_limit == '0) ? 1 : int'(cfg.step_limit);
            for (int c = 0; c < CHANNELS; c++) begin
               if (present[c] && enabled[c]) begin
                  diff = int'(tgt_angle[c]) - int'(cur_angle[c]);
                  if ((diff < 0 ? -diff : diff) > int'(cfg.deadband)) begin
                     if (diff > lim) diff = lim;
                     if (diff < -lim) diff = -lim;
                     nxt = int'(cur_angle[c]) + diff;
                     if (nxt < 0) nxt = 0;
                     if (nxt > int'(FULL_SCALE)) nxt = int'(FULL_SCALE);
                     cur_angle[c]     = ANG_W'(nxt);
                     item.out_channel = CH_W'(c);
                     item.pulse       = angle_to_count(cur_angle[c]);
                     item.last        = 1'b0;
                     pulse_q.push_back(item);
                     moved = 1'b1;
                  end
               end
            end
            // flag the end of the sweep on its final result
            if (moved) begin
               item      = pulse_q.pop_back();
               item.last = 1'b1;
               pulse_q.push_back(item);
            end
         end
         OP_PLACE: begin
            if (int'(r.channel) < CHANNELS) begin
               present[r.channel]   = 1'b1;
               enabled[r.channel]   = 1'b1;
               cur_angle[r.channel] = ang;
               tgt_angle[r.channel] = ang;
               item.out_channel     = r.channel;
               item.pulse           = angle_to_count(ang);
               item.last            = 1'b1;
               pulse_q.push_back(item);
            end
         end
         OP_TARGET: begin
            if (int'(r.channel) < CHANNELS) tgt_angle[r.channel] = ang;
         end
         OP_ENABLE: begin
            if (int'(r.channel) < CHANNELS) enabled[r.channel] = r.enable;
         end
      endcase
   endtask

   task automatic compare_field(input string name, input logic [PULSE_W-1:0] want,
                                input logic [PULSE_W-1:0] got);
      if (want !== got)
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
   endtask

   task automatic match_result(input ssr_rsp_type got);
      ssr_rsp_type want;
      if (pulse_q.size() == 0) begin
         failures++;
         $display("%0t: unexpected result, expected none, actual channel %0d pulse %0d last %0b",
                  $time, got.out_channel, got.pulse, got.last);
      end else begin
         want = pulse_q.pop_front();
         if (got !== want) begin
            failures++;
            compare_field("out_channel", PULSE_W'(want.out_channel), PULSE_W'(got.out_channel));
            compare_field("pulse", want.pulse, got.pulse);
            compare_field("last", PULSE_W'(want.last), PULSE_W'(got.last));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg.step_limit = STEP_LIMIT_RST;
         cfg.deadband   = DEADBAND_RST;
         cfg.pulse_min  = PULSE_MIN_RST;
         cfg.pulse_max  = PULSE_MAX_RST;
         for (int c = 0; c < CHANNELS; c++) begin
            present[c] = 1'b0;
            enabled[c] = 1'b0;
         end
         pulse_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_STEP_LIMIT: cfg.step_limit = csr_wdata[STEP_W-1:0];
               CSR_DEADBAND:   cfg.deadband   = csr_wdata[DB_W-1:0];
               CSR_PULSE_MIN:  cfg.pulse_min  = csr_wdata[PULSE_W-1:0];
               CSR_PULSE_MAX:  cfg.pulse_max  = csr_wdata[PULSE_W-1:0];
            endcase
         end
         if (req_valid && req_ready) ramp_request(req_data);
         if (rsp_valid && rsp_ready) match_result(rsp_data);
      end
      pending    <= pulse_q.size();
      fail_count <= failures;
   end

endmodule

// ----- test/servo_slew_ramp_core_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// servo_slew_ramp_core_tb : top level testbench for the servo ramp core
// Drives request transactions and register writes, stalls the response
// side at random, and leaves prediction and checking to the ramp checker.
// ============================================================================
module servo_slew_ramp_core_tb;
   import ssr_pkg::*;

   // random request transactions per register setting
   localparam int PHASE_ITEMS    = 38;
   localparam int PHASES         = 6;
   // a tick holds the sweep engine over all channels and up to two more
   // requests may sit in the command queue, so this covers a silent backlog
   localparam int SETTLE_CYCLES  = 100;
   // longest stretch with no transaction on either channel
   localparam int WATCHDOG_LIMIT = 4000;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   ssr_req_type           req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   ssr_rsp_type           rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_STEP_LIMIT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    fail_count;
   int                    pending;
   // high in the closing phase: no idling on either side
   logic                  calm        = 1'b0;
   int                    stall_left  = 0;
   int                    idle_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   servo_slew_ramp_core #(
      .CHANNELS (CHANNELS_DEF)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   servo_ramp_checker #(
      .CHANNELS (CHANNELS_DEF)
   ) i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Stall the response side in bursts of random length; between bursts
   // ready stays high, which gives stretches with no stall at all.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Count cycles without any transaction; give up when the core hangs.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Present one request transaction and hold it until accepted. Valid is
   // left high on return so back-to-back transactions never drop it; an
   // idle burst lowers it first.
   task automatic send(input logic [1:0] op, input int ch, input int ang, input logic en);
      int          gap;
      ssr_req_type item;
      gap = 0;
      if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item.req_type = op;
      item.channel  = CH_W'(ch);
      item.angle    = ANG_W'(ang);
      item.enable   = en;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // Mostly in-range angles, with the end stops and over-range values mixed in.
   function automatic int pick_angle();
      int unsigned sel;
      sel = $urandom_range(0, 19);
      case (sel)
         0:       return 0;
         1:       return int'(FULL_SCALE);
         2:       return int'($urandom_range(int'(FULL_SCALE) + 1, 32767));
         default: return int'($urandom_range(0, int'(FULL_SCALE)));
      endcase
   endfunction

   // Ticks and target moves dominate so that ramps run for many steps;
   // unused fields carry random content.
   task automatic send_random();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 42)
         send(OP_TICK, int'($urandom_range(0, 15)), pick_angle(), 1'($urandom_range(0, 1)));
      else if (pick < 72)
         send(OP_TARGET, int'($urandom_range(0, 15)), pick_angle(), 1'($urandom_range(0, 1)));
      else if (pick < 86)
         send(OP_PLACE, int'($urandom_range(0, 15)), pick_angle(), 1'($urandom_range(0, 1)));
      else
         send(OP_ENABLE, int'($urandom_range(0, 15)), pick_angle(), $urandom_range(0, 4) != 0);
   endtask

   // Drop valid, wait out every expected result, then let a silent tick or
   // a queued request finish before anything touches the registers.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [CSR_DATA_W-1:0] step_val,
                                input logic [CSR_DATA_W-1:0] db_val,
                                input logic [CSR_DATA_W-1:0] lo_val,
                                input logic [CSR_DATA_W-1:0] hi_val);
      write_reg(CSR_STEP_LIMIT, step_val);
      write_reg(CSR_DEADBAND, db_val);
      write_reg(CSR_PULSE_MIN, lo_val);
      write_reg(CSR_PULSE_MAX, hi_val);
      csr_we <= 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed transactions under the reset register values.
      send(OP_TICK, 0, 0, 1'b0);              // nothing present: no result
      send(OP_ENABLE, 3, 0, 1'b0);            // enable flag on an absent channel
      send(OP_TARGET, 3, 5000, 1'b1);         // target on an absent channel
      send(OP_TICK, 0, 0, 1'b0);              // absent channel must not move
      send(OP_PLACE, 3, 9000, 1'b0);          // place overrides target and enable
      send(OP_TICK, 0, 0, 1'b0);              // at target: no result
      send(OP_PLACE, 0, 0, 1'b1);             // low end stop
      send(OP_PLACE, 15, 32767, 1'b1);        // over-range angle saturates
      send(OP_PLACE, 8, 18001, 1'b0);         // just over full scale
      send(OP_TARGET, 0, 18000, 1'b0);
      send(OP_TARGET, 15, 0, 1'b1);
      send(OP_TARGET, 3, 9010, 1'b0);         // difference equal to deadband: hold
      send(OP_TICK, 0, 0, 1'b0);
      send(OP_TARGET, 3, 9011, 1'b0);         // one past deadband: move
      send(OP_ENABLE, 15, 0, 1'b0);           // park channel 15
      send(OP_TICK, 0, 0, 1'b0);
      send(OP_ENABLE, 15, 0, 1'b1);
      send(OP_TARGET, 8, 32767, 1'b0);        // saturated target equals current
      send(OP_PLACE, 5, 100, 1'b0);
      send(OP_TARGET, 5, 40, 1'b0);           // move shorter than the step limit
      send(OP_PLACE, 10, 16383, 1'b1);
      send(OP_TARGET, 10, 10922, 1'b0);
      send(OP_TICK, 0, 0, 1'b0);
      send(OP_TICK, 0, 0, 1'b0);

      // Random transactions under several register settings; every change
      // happens with the core drained.
      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         case (ph)
            // zero step limit acts as one, no deadband, full pulse span
            0: apply_setting(15'd0, 15'd0, 15'd0, 15'd4095);
            // single-tick jumps, wide deadband, inverted span
            1: apply_setting(15'd18000, 15'd1000, 15'd4095, 15'd0);
            // all ones: upper bits beyond each register must be dropped
            2: apply_setting(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'd0);
            3: apply_setting(CSR_DATA_W'($urandom_range(1, 400)),
                             CSR_DATA_W'($urandom_range(0, 60)),
                             CSR_DATA_W'($urandom_range(0, 4095)),
                             CSR_DATA_W'($urandom_range(0, 4095)));
            4: apply_setting(15'd1, 15'd0, 15'd600, 15'd150);
            default: begin
               // closing phase: back to reset values, no idling
               calm <= 1'b1;
               apply_setting(CSR_DATA_W'(STEP_LIMIT_RST), CSR_DATA_W'(DEADBAND_RST),
                             CSR_DATA_W'(PULSE_MIN_RST), CSR_DATA_W'(PULSE_MAX_RST));
            end
         endcase
         repeat (PHASE_ITEMS) send_random();
      end

      settle();
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- servo_slew_ramp_core.f -----
hdl/ssr_pkg.sv
hdl/ssr_front.sv
hdl/ssr_cmd_queue.sv
hdl/ssr_back.sv
hdl/ssr_scaler.sv
hdl/servo_slew_ramp_core.sv
test/servo_ramp_checker.sv
test/servo_slew_ramp_core_tb.sv
